[src/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Action and status codes, ring geometry and the request/response payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   // Ring geometry; the depth is a power of two so indexes wrap by truncation
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = 5;
   localparam int WORD_W  = 32;
   localparam int ACT_W   = 3;
   localparam int STS_W   = 2;

   // Action codes; the remaining codes behave as no operation
   localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NOP        = 3'd4;

   // Status codes
   localparam logic [STS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

   // Word returned for front and rear while the queue is empty
   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic signed [WORD_W-1:0] data_value;
   } req_data_type;

   typedef struct packed {
      logic [STS_W-1:0]         status;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
      logic                     is_empty;
      logic [CNT_W-1:0]         entry_count;
   } rsp_data_type;

endpackage

`default_nettype wire

[src/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded deque of 32-bit words in a ring memory
// A transferred request updates index, count and memory in the idle state; the read
// state then registers the front and rear words from the two memory read ports and
// sets response valid. A new request waits for idle and a free response slot.
// Reset: front index, count, state and response valid clear; the ring memory
// is not cleared, since only entries written by a push are ever returned.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  dq_pkg::req_data_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output dq_pkg::rsp_data_type rsp_data
);
   import dq_pkg::*;

   typedef enum logic [1:0] {
      IDLE_S = 2'b01,
      READ_S = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        front_ff, front_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [STS_W-1:0]        status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0] front_rd_ff, rear_rd_ff;
   logic signed [WORD_W-1:0] ring_mem [DEPTH];

   logic                    req_xfer;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [IDX_W-1:0]        rear_addr;
   logic                    is_full;
   logic                    is_empty;

   // Accept only in the idle state while the response slot is empty or being taken
   assign req_ready = (state_ff == IDLE_S) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   // Decode the action and compute the next index, count, status and write
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = front_ff;
      if (req_xfer) begin
         status_in = STS_OK;
         unique case (req_data.action)
            ACT_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = STS_FULL;
               end else begin
                  front_in = front_ff - 1'b1;
                  wr_addr  = front_ff - 1'b1;
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_PUSH_REAR: begin
               if (is_full) begin
                  status_in = STS_FULL;
               end else begin
                  wr_addr  = front_ff + count_ff[IDX_W-1:0];
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_POP_FRONT: begin
               if (is_empty) begin
                  status_in = STS_EMPTY;
               end else begin
                  front_in = front_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            ACT_POP_REAR: begin
               if (is_empty) begin
                  status_in = STS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               // no operation, including unused codes
            end
         endcase
      end
   end

   // Rear entry of the updated ring
   assign rear_addr = IDX_W'(front_ff + count_ff - 1'b1);

   // Sequence: update in the idle state, then read in the read state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         IDLE_S: begin
            if (req_xfer) begin
               state_in = READ_S;
            end
         end
         READ_S: begin
            state_in     = IDLE_S;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = IDLE_S;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_S;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the status of the last transfer
   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // Write pushed words; read front and rear in the cycle after the update
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= req_data.data_value;
      end
      if (state_ff == READ_S) begin
         front_rd_ff <= ring_mem[front_ff];
         rear_rd_ff  <= ring_mem[rear_addr];
      end
   end

   // Drive the response from the held status, count and read words
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.front_value = is_empty ? EMPTY_WORD : front_rd_ff;
   assign rsp_data.rear_value  = is_empty ? EMPTY_WORD : rear_rd_ff;
   assign rsp_data.is_empty    = is_empty;
   assign rsp_data.entry_count = count_ff;

endmodule

`default_nettype wire

[src/dq_checker.sv]
// ----------------------------------------------------------------------------
// dq_checker: port-level checks for the double-ended queue
// Watches the request and response channels and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input dq_pkg::req_data_type req_data,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input dq_pkg::rsp_data_type rsp_data
);
   import dq_pkg::*;

   // Hold a stalled response unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Every transfer is followed by its response once the read state has passed
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("response missing after request transfer");

   // Empty flag follows the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == '0)))
      else $error("empty flag disagrees with count");

   // Empty queue reads -1 at both ends
   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         (rsp_data.front_value == EMPTY_WORD) && (rsp_data.rear_value == EMPTY_WORD))
      else $error("empty queue returned a stored word");

   // A single entry is both front and rear
   a_single_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.entry_count == CNT_W'(1)) |->
         (rsp_data.front_value == rsp_data.rear_value))
      else $error("front and rear differ with one entry");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[bench/double_ended_queue_top_tb.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb: self-checking bench for the bounded deque
// Drives push/pop/no-op requests through the valid/ready request channel,
// mirrors the ring in a local deque model and compares every response field.
// A short directed table runs first, then biased random fill/drain traffic
// under three idling profiles.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
   import dq_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PER_PHASE = 191;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      req_data_type req;
      bit           typed;
      rsp_data_type rsp;
   } directed_step_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_data_type rsp_data;

   // Typed expectation that travels alongside the request in flight
   logic         row_typed = 1'b0;
   rsp_data_type row_rsp = '0;

   int req_idle_pct = 37;
   int rsp_idle_pct = 60;
   int mismatch_count = 0;
   int stall_cycles = 0;

   // Local copy of the deque
   logic signed [WORD_W-1:0] ring_words [DEPTH];
   logic [IDX_W-1:0]         head_idx;
   logic [CNT_W-1:0]         held;

   rsp_data_type expected_rsp_q [$];
   directed_step_type directed_steps [$];

   double_ended_queue_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Apply one action to the local deque and return the response it yields
   function automatic rsp_data_type apply_deque_action(req_data_type r);
      rsp_data_type res;
      logic [IDX_W-1:0] slot;
      res = '0;
      res.status = STS_OK;
      case (r.action)
         ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
            if (held == DEPTH) begin
               res.status = STS_FULL;
            end else if (r.action == ACT_PUSH_FRONT) begin
               head_idx = head_idx - 1'b1;
               ring_words[head_idx] = r.data_value;
               held = held + 1'b1;
            end else begin
               slot = head_idx + held[IDX_W-1:0];
               ring_words[slot] = r.data_value;
               held = held + 1'b1;
            end
         end
         ACT_POP_FRONT, ACT_POP_REAR: begin
            if (held == 0) begin
               res.status = STS_EMPTY;
            end else begin
               if (r.action == ACT_POP_FRONT) begin
                  head_idx = head_idx + 1'b1;
               end
               held = held - 1'b1;
            end
         end
         default: ;
      endcase
      if (held == 0) begin
         res.front_value = EMPTY_WORD;
         res.rear_value  = EMPTY_WORD;
         res.is_empty    = 1'b1;
      end else begin
         slot = head_idx + held[IDX_W-1:0] - 1'b1;
         res.front_value = ring_words[head_idx];
         res.rear_value  = ring_words[slot];
         res.is_empty    = 1'b0;
      end
      res.entry_count = held;
      return res;
   endfunction

   task automatic note_mismatch(string what, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch %0s: expected %h, got %h", what, want, got);
      end
   endtask

   // Score responses against the oldest expectation, queue new expectations
   always @(posedge clock) begin : scoreboard
      rsp_data_type want;
      if (reset) begin
         head_idx = '0;
         held = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               note_mismatch("response with none outstanding", '0, '0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status)
                  note_mismatch("status", WORD_W'(want.status), WORD_W'(rsp_data.status));
               if (rsp_data.front_value !== want.front_value)
                  note_mismatch("front_value", want.front_value, rsp_data.front_value);
               if (rsp_data.rear_value !== want.rear_value)
                  note_mismatch("rear_value", want.rear_value, rsp_data.rear_value);
               if (rsp_data.is_empty !== want.is_empty)
                  note_mismatch("is_empty", WORD_W'(want.is_empty),
                                WORD_W'(rsp_data.is_empty));
               if (rsp_data.entry_count !== want.entry_count)
                  note_mismatch("entry_count", WORD_W'(want.entry_count),
                                WORD_W'(rsp_data.entry_count));
            end
         end
         if (req_valid && req_ready) begin
            want = apply_deque_action(req_data);
            if (row_typed) begin
               want = row_rsp;
            end
            expected_rsp_q.push_back(want);
         end
      end
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Abort when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Offer one request, idling first at random, and hold it until transfer
   task automatic send_request(logic [ACT_W-1:0] act, logic signed [WORD_W-1:0] value,
                               bit typed, rsp_data_type typed_rsp);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{action: act, data_value: value};
      row_typed <= typed;
      row_rsp   <= typed_rsp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding response has come back
   task automatic drain_responses();
      req_valid <= 1'b0;
      row_typed <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(15))
         0: return '0;
         1: return -32'sd1;
         2: return 32'sh7FFF_FFFF;
         3: return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      directed_step_type step;
      rsp_data_type   empty_rsp;
      logic [ACT_W-1:0] act;
      bit fill_bias;
      int run_left;
      int r;

      empty_rsp = '{STS_OK, EMPTY_WORD, EMPTY_WORD, 1'b1, 5'd0};

      // Pops on the empty deque, extremes pushed at both ends
      step = '{'{ACT_POP_FRONT, 32'sd5}, 1'b1, empty_rsp};
      step.rsp.status = STS_EMPTY;
      directed_steps.push_back(step);
      step.req.action = ACT_POP_REAR;
      directed_steps.push_back(step);
      directed_steps.push_back('{'{ACT_PUSH_FRONT, 32'sh7FFF_FFFF}, 1'b1,
         '{STS_OK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 5'd1}});
      directed_steps.push_back('{'{ACT_PUSH_REAR, 32'sh8000_0000}, 1'b1,
         '{STS_OK, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 5'd2}});
      // Undefined action code behaves as no operation
      directed_steps.push_back('{'{{ACT_W{1'b1}}, 32'sd9}, 1'b0, empty_rsp});
      directed_steps.push_back('{'{ACT_POP_FRONT, '0}, 1'b0, empty_rsp});
      directed_steps.push_back('{'{ACT_POP_REAR, '0}, 1'b1, empty_rsp});
      // Fill to capacity from both ends, then push on full and pop back
      for (int i = 0; i < DEPTH; i++) begin
         act = i[0] ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
         directed_steps.push_back('{'{act, i[0] ? ~(i * 32'h0101_0101) : i * 32'h1020_3040},
                                    1'b0, empty_rsp});
      end
      directed_steps.push_back('{'{ACT_PUSH_FRONT, 32'sd1}, 1'b0, empty_rsp});
      directed_steps.push_back('{'{ACT_PUSH_REAR, -32'sd1}, 1'b0, empty_rsp});
      directed_steps.push_back('{'{ACT_POP_REAR, '0}, 1'b0, empty_rsp});
      directed_steps.push_back('{'{ACT_POP_FRONT, '0}, 1'b0, empty_rsp});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         send_request(directed_steps[i].req.action, directed_steps[i].req.data_value,
                      directed_steps[i].typed, directed_steps[i].rsp);
      end
      drain_responses();

      // Random fill/drain runs under three idling profiles
      fill_bias = 1'b0;
      run_left = 0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_idle_pct = 37; rsp_idle_pct = 60; end
            1: begin req_idle_pct = 60; rsp_idle_pct = 37; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (run_left == 0) begin
               fill_bias = !fill_bias;
               run_left = $urandom_range(8, 40);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 8) begin
               act = ACT_W'($urandom_range(ACT_NOP, {ACT_W{1'b1}}));
            end else if ((r < 70) == fill_bias) begin
               act = $urandom_range(1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
            end else begin
               act = $urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT;
            end
            send_request(act, pick_word(), 1'b0, empty_rsp);
         end
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
